// ===== src/dgem_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dgem_pkg
// Shared constants, types and helpers for the dual gamepad event merger.
// ============================================================================
package dgem_pkg;

  localparam int KEY_CODE_BITS = 10;
  localparam int CODE_W        = 10;
  localparam int VAL_W         = 16;
  localparam int MAG_W         = VAL_W + 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 50;
  localparam int FUZZ_W        = 15;
  localparam int FLAT_W        = 16;
  localparam int INV_W         = 4;
  localparam int LMAP_W        = 50;
  localparam int FMAP_W        = 40;
  localparam int OMAP_W        = 50;
  localparam int DIV_STEPS     = MAG_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  // register indices
  localparam logic [CFG_IDX_W-1:0] REG_FUZZ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LMAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FMAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OMAP  = 3'd5;

  localparam logic [FUZZ_W-1:0] FUZZ_RST = 15'd256;
  localparam logic [FLAT_W-1:0] FLAT_RST = 16'd4096;
  localparam logic [INV_W-1:0]  INV_RST  = 4'd0;
  localparam logic [LMAP_W-1:0] LMAP_RST = {10'd167, 10'd317, 10'd314, 10'd312, 10'd310};
  localparam logic [FMAP_W-1:0] FMAP_RST = {10'd308, 10'd307, 10'd305, 10'd304};
  localparam logic [OMAP_W-1:0] OMAP_RST = {10'd316, 10'd318, 10'd315, 10'd313, 10'd311};

  // event kinds in
  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_AXIS  = 2'd1;
  localparam logic [1:0] CMD_SYNC  = 2'd2;

  // event kinds out
  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_AXIS = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;

  localparam logic [CODE_W-1:0] KEY_L       = 10'h136;
  localparam logic [CODE_W-1:0] KEY_ZL      = 10'h138;
  localparam logic [CODE_W-1:0] KEY_MINUS   = 10'h13a;
  localparam logic [CODE_W-1:0] KEY_L3      = 10'h13d;
  localparam logic [CODE_W-1:0] KEY_CAPTURE = 10'h135;
  localparam logic [CODE_W-1:0] KEY_A       = 10'd304;
  localparam logic [CODE_W-1:0] KEY_B       = 10'd305;
  localparam logic [CODE_W-1:0] KEY_X       = 10'd307;
  localparam logic [CODE_W-1:0] KEY_Y       = 10'd308;
  localparam logic [CODE_W-1:0] KEY_R       = 10'h137;
  localparam logic [CODE_W-1:0] KEY_ZR      = 10'h139;
  localparam logic [CODE_W-1:0] KEY_PLUS    = 10'h13b;
  localparam logic [CODE_W-1:0] KEY_R3      = 10'h13e;
  localparam logic [CODE_W-1:0] KEY_HOME    = 10'h13c;
  localparam logic [CODE_W-1:0] PAD_UP      = 10'd544;
  localparam logic [CODE_W-1:0] PAD_RIGHT   = 10'd547;
  localparam logic [CODE_W-1:0] HAT_X       = 10'd16;
  localparam logic [CODE_W-1:0] HAT_Y       = 10'd17;
  localparam logic [CODE_W-1:0] AXIS_LX     = 10'd0;
  localparam logic [CODE_W-1:0] AXIS_LY     = 10'd1;
  localparam logic [CODE_W-1:0] AXIS_RX     = 10'd3;
  localparam logic [CODE_W-1:0] AXIS_RY     = 10'd4;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_KEY,
    CLS_PAD,
    CLS_AXIS,
    CLS_SYNC
  } cls_t;

  typedef struct packed {
    logic       take;
    logic       prep;
    logic       step;
    logic [1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic last;
  } dp_stat_t;

  function automatic logic [CODE_W-1:0] map_code(input logic [63:0] map,
                                                 input logic [2:0]  idx);
    logic [31:0] sh;
    logic [63:0] s;
    sh = 32'(idx) * 32'(KEY_CODE_BITS);
    s  = map >> sh[5:0];
    if (sh >= 32'd64) begin
      return '0;
    end
    return s[CODE_W-1:0];
  endfunction

endpackage

// ===== src/dgem_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dgem_ctrl
// Sequencer: accept, decode, divider steps and result beats.
// ============================================================================
module dgem_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 evt_valid,
  output logic                 evt_stall,
  output logic                 res_valid,
  input  logic                 res_stall,
  input  dgem_pkg::dp_stat_t   stat,
  output dgem_pkg::ctrl_cmd_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  localparam logic [dgem_pkg::DIV_CNT_W-1:0] CNT_LAST =
    dgem_pkg::DIV_CNT_W'(dgem_pkg::DIV_STEPS - 1);

  state_t                          state, state_next;
  logic [dgem_pkg::DIV_CNT_W-1:0]  cnt, cnt_next;
  logic [1:0]                      idx, idx_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (evt_valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cnt_next = '0;
        idx_next = '0;
        case (stat.cls)
          dgem_pkg::CLS_NONE: state_next = S_IDLE;
          dgem_pkg::CLS_AXIS: state_next = S_DIV;
          default:            state_next = S_EMIT;
        endcase
      end
      S_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!res_stall) begin
          if (stat.last) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
    end
  end

  assign evt_stall = (state != S_IDLE);
  assign res_valid = (state == S_EMIT);
  assign ctl.take  = evt_valid && (state == S_IDLE);
  assign ctl.prep  = (state == S_PREP);
  assign ctl.step  = (state == S_DIV);
  assign ctl.idx   = idx;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> evt_stall)
    else $error("result beat while input open");

  a_take_prep: assert property (@(posedge clk) disable iff (rst)
    ctl.take |=> ctl.prep)
    else $error("accepted item not decoded next cycle");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && cnt == CNT_LAST) |=> res_valid)
    else $error("divider end not followed by result");

  a_beat_adv: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !stat.last) |=>
      (res_valid && idx == 2'($past(idx) + 2'd1)))
    else $error("beat index did not advance");

  a_none_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.prep && stat.cls == dgem_pkg::CLS_NONE) |=> !evt_stall)
    else $error("item without results did not release input");
`endif

endmodule

// ===== src/dgem_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dgem_dp
// Datapath: config registers, decode, pad levels, remainder unit, results.
// ============================================================================
module dgem_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [dgem_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dgem_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   side,
  input  logic [1:0]                             cmd,
  input  logic [dgem_pkg::CODE_W-1:0]            event_code,
  input  logic signed [dgem_pkg::VAL_W-1:0]      event_value,
  input  dgem_pkg::ctrl_cmd_t                    ctl,
  output dgem_pkg::dp_stat_t                     stat,
  output logic [1:0]                             out_kind,
  output logic [dgem_pkg::CODE_W-1:0]            out_code,
  output logic signed [dgem_pkg::VAL_W-1:0]      out_value,
  output logic                                   last
);

  logic [dgem_pkg::FUZZ_W-1:0] fuzz;
  logic [dgem_pkg::FLAT_W-1:0] flat;
  logic [dgem_pkg::INV_W-1:0]  inv;
  logic [dgem_pkg::LMAP_W-1:0] lmap;
  logic [dgem_pkg::FMAP_W-1:0] fmap;
  logic [dgem_pkg::OMAP_W-1:0] omap;

  logic                          side_q;
  logic [1:0]                    cmd_q;
  logic [dgem_pkg::CODE_W-1:0]   code_q;
  logic [dgem_pkg::VAL_W-1:0]    val_q;
  dgem_pkg::cls_t                cls_q;
  logic [dgem_pkg::CODE_W-1:0]   kcode_q;
  logic [1:0]                    dpad [4];
  logic                          sgn;
  logic [dgem_pkg::MAG_W-1:0]    mag;
  logic [dgem_pkg::MAG_W-1:0]    dq;
  logic [dgem_pkg::MAG_W-1:0]    rem;

  dgem_pkg::cls_t                cls_d;
  logic [dgem_pkg::CODE_W-1:0]   kcode_d;
  logic [1:0]                    bsel;
  logic [dgem_pkg::MAG_W-1:0]    v17;
  logic [dgem_pkg::MAG_W-1:0]    mag_d;
  logic [dgem_pkg::MAG_W-1:0]    rem_sh;
  logic [dgem_pkg::MAG_W-1:0]    fz_ext;
  logic [dgem_pkg::MAG_W-1:0]    qmag;
  logic [dgem_pkg::VAL_W-1:0]    axis_val;
  logic [2:0]                    hx;
  logic [2:0]                    hy;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      fuzz <= dgem_pkg::FUZZ_RST;
      flat <= dgem_pkg::FLAT_RST;
      inv  <= dgem_pkg::INV_RST;
      lmap <= dgem_pkg::LMAP_RST;
      fmap <= dgem_pkg::FMAP_RST;
      omap <= dgem_pkg::OMAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dgem_pkg::REG_FUZZ: fuzz <= cfg_data[dgem_pkg::FUZZ_W-1:0];
        dgem_pkg::REG_FLAT: flat <= cfg_data[dgem_pkg::FLAT_W-1:0];
        dgem_pkg::REG_INV:  inv  <= cfg_data[dgem_pkg::INV_W-1:0];
        dgem_pkg::REG_LMAP: lmap <= cfg_data[dgem_pkg::LMAP_W-1:0];
        dgem_pkg::REG_FMAP: fmap <= cfg_data[dgem_pkg::FMAP_W-1:0];
        dgem_pkg::REG_OMAP: omap <= cfg_data[dgem_pkg::OMAP_W-1:0];
        default: ;
      endcase
    end
  end

  // decode of the held item
  always_comb begin
    cls_d   = dgem_pkg::CLS_NONE;
    kcode_d = '0;
    bsel    = code_q[1:0];
    case (cmd_q)
      dgem_pkg::CMD_KEY: begin
        if (!side_q) begin
          cls_d = dgem_pkg::CLS_KEY;
          if (code_q == dgem_pkg::KEY_L) begin
            kcode_d = dgem_pkg::map_code(64'(lmap), 3'd0);
          end else if (code_q == dgem_pkg::KEY_ZL) begin
            kcode_d = dgem_pkg::map_code(64'(lmap), 3'd1);
          end else if (code_q == dgem_pkg::KEY_MINUS) begin
            kcode_d = dgem_pkg::map_code(64'(lmap), 3'd2);
          end else if (code_q == dgem_pkg::KEY_L3) begin
            kcode_d = dgem_pkg::map_code(64'(lmap), 3'd3);
          end else if (code_q == dgem_pkg::KEY_CAPTURE) begin
            kcode_d = dgem_pkg::map_code(64'(lmap), 3'd4);
          end else if (code_q inside {[dgem_pkg::PAD_UP:dgem_pkg::PAD_RIGHT]}) begin
            cls_d = dgem_pkg::CLS_PAD;
          end else begin
            cls_d = dgem_pkg::CLS_NONE;
          end
        end else begin
          cls_d = dgem_pkg::CLS_KEY;
          if (code_q == dgem_pkg::KEY_A) begin
            kcode_d = dgem_pkg::map_code(64'(fmap), 3'd0);
          end else if (code_q == dgem_pkg::KEY_B) begin
            kcode_d = dgem_pkg::map_code(64'(fmap), 3'd1);
          end else if (code_q == dgem_pkg::KEY_X) begin
            kcode_d = dgem_pkg::map_code(64'(fmap), 3'd2);
          end else if (code_q == dgem_pkg::KEY_Y) begin
            kcode_d = dgem_pkg::map_code(64'(fmap), 3'd3);
          end else if (code_q == dgem_pkg::KEY_R) begin
            kcode_d = dgem_pkg::map_code(64'(omap), 3'd0);
          end else if (code_q == dgem_pkg::KEY_ZR) begin
            kcode_d = dgem_pkg::map_code(64'(omap), 3'd1);
          end else if (code_q == dgem_pkg::KEY_PLUS) begin
            kcode_d = dgem_pkg::map_code(64'(omap), 3'd2);
          end else if (code_q == dgem_pkg::KEY_R3) begin
            kcode_d = dgem_pkg::map_code(64'(omap), 3'd3);
          end else if (code_q == dgem_pkg::KEY_HOME) begin
            kcode_d = dgem_pkg::map_code(64'(omap), 3'd4);
          end else begin
            cls_d = dgem_pkg::CLS_NONE;
          end
        end
      end
      dgem_pkg::CMD_AXIS: begin
        if (!side_q && code_q inside {dgem_pkg::AXIS_LX, dgem_pkg::AXIS_LY}) begin
          cls_d = dgem_pkg::CLS_AXIS;
          bsel  = code_q[1:0];
        end else if (side_q && code_q inside {dgem_pkg::AXIS_RX, dgem_pkg::AXIS_RY}) begin
          cls_d = dgem_pkg::CLS_AXIS;
          bsel  = 2'(code_q[2:0] - 3'd1);
        end
      end
      dgem_pkg::CMD_SYNC: cls_d = dgem_pkg::CLS_SYNC;
      default:            cls_d = dgem_pkg::CLS_NONE;
    endcase
  end

  // optional negation, then sign and magnitude
  always_comb begin
    v17 = {val_q[dgem_pkg::VAL_W-1], val_q};
    if (inv[bsel]) begin
      v17 = -v17;
    end
    mag_d = v17[dgem_pkg::MAG_W-1] ? -v17 : v17;
  end

  assign fz_ext = {2'b00, fuzz};
  assign rem_sh = {rem[dgem_pkg::MAG_W-2:0], dq[dgem_pkg::MAG_W-1]};

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      side_q <= side;
      cmd_q  <= cmd;
      code_q <= event_code;
      val_q  <= event_value;
    end
    if (ctl.prep) begin
      cls_q   <= cls_d;
      kcode_q <= kcode_d;
      sgn     <= v17[dgem_pkg::MAG_W-1];
      mag     <= mag_d;
      dq      <= mag_d;
      rem     <= '0;
    end else if (ctl.step) begin
      // restoring remainder, one dividend bit a cycle
      dq <= {dq[dgem_pkg::MAG_W-2:0], 1'b0};
      if (rem_sh >= fz_ext) begin
        rem <= rem_sh - fz_ext;
      end else begin
        rem <= rem_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        dpad[i] <= '0;
      end
    end else if (ctl.prep && cls_d == dgem_pkg::CLS_PAD) begin
      dpad[code_q[1:0]] <= val_q[1:0];
    end
  end

  // conditioned stick value
  always_comb begin
    qmag = (fuzz > 15'd1) ? (mag - rem) : mag;
    if (mag < {1'b0, flat}) begin
      axis_val = '0;
    end else if (sgn) begin
      axis_val = dgem_pkg::VAL_W'(-qmag);
    end else if (qmag > 17'd32767) begin
      axis_val = 16'h7fff;
    end else begin
      axis_val = qmag[dgem_pkg::VAL_W-1:0];
    end
  end

  assign hx = {1'b0, dpad[3]} - {1'b0, dpad[2]};
  assign hy = {1'b0, dpad[1]} - {1'b0, dpad[0]};

  always_comb begin
    out_kind  = dgem_pkg::KIND_SYNC;
    out_code  = '0;
    out_value = '0;
    last      = 1'b1;
    case (cls_q)
      dgem_pkg::CLS_KEY: begin
        out_kind  = dgem_pkg::KIND_KEY;
        out_code  = kcode_q;
        out_value = val_q;
      end
      dgem_pkg::CLS_PAD: begin
        case (ctl.idx)
          2'd0: begin
            out_kind  = dgem_pkg::KIND_AXIS;
            out_code  = dgem_pkg::HAT_X;
            out_value = {{(dgem_pkg::VAL_W-3){hx[2]}}, hx};
            last      = 1'b0;
          end
          2'd1: begin
            out_kind  = dgem_pkg::KIND_AXIS;
            out_code  = dgem_pkg::HAT_Y;
            out_value = {{(dgem_pkg::VAL_W-3){hy[2]}}, hy};
            last      = 1'b0;
          end
          default: ;
        endcase
      end
      dgem_pkg::CLS_AXIS: begin
        out_kind  = dgem_pkg::KIND_AXIS;
        out_code  = code_q;
        out_value = axis_val;
      end
      default: ;
    endcase
  end

  assign stat.cls  = cls_d;
  assign stat.last = last;

endmodule

// ===== src/dual_gamepad_event_merger.sv =====
`timescale 1ns / 1ps
// Timing: an accepted item is decoded, then its result beats follow; axis events
//   first pass through the 17-step serial remainder unit.
// Beats: n = 1..3 per item; a new item is accepted only after the last beat,
//   later while the result side stalls; no-result items release the input after decode.
// Reset: registers return to defaults, pad levels clear, no clearing pass.
// ============================================================================
// dual_gamepad_event_merger
// Merges left and right half-controller events into one gamepad stream.
// ============================================================================
module dual_gamepad_event_merger (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                evt_valid,
  output logic                                evt_stall,
  input  logic                                side,
  input  logic [1:0]                          cmd,
  input  logic [dgem_pkg::CODE_W-1:0]         event_code,
  input  logic signed [dgem_pkg::VAL_W-1:0]   event_value,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [1:0]                          out_kind,
  output logic [dgem_pkg::CODE_W-1:0]         out_code,
  output logic signed [dgem_pkg::VAL_W-1:0]   out_value,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dgem_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dgem_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dgem_pkg::ctrl_cmd_t ctl;
  dgem_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  dgem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  dgem_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .side        (side),
    .cmd         (cmd),
    .event_code  (event_code),
    .event_value (event_value),
    .ctl         (ctl),
    .stat        (stat),
    .out_kind    (out_kind),
    .out_code    (out_code),
    .out_value   (out_value),
    .last        (last)
  );

endmodule
